### hw/rtl/casd_pkg.sv
// ----------------------------------------------------------------------------
// casd_pkg: shared types and constants of the amplitude switch detector
// Holds the sample width, the register map and the running-extremes record
// that the tracker hands to the top level.
// ----------------------------------------------------------------------------
package casd_pkg;

    // Width of one converter reading and of the reported amplitude.
    localparam int SAMPLE_BITS = 10;

    // Configuration register widths.
    localparam int WLEN_W = 7;
    localparam int THR_W  = 10;
    localparam int TRIM_W = 1;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIM_MODE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_THRESHOLD  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RST = 7'd32;
    localparam logic [TRIM_W-1:0] TRIM_MODE_RST     = 1'b0;
    localparam logic [THR_W-1:0]  ON_THRESHOLD_RST  = 10'd15;

    // Shortest window the block will run.
    localparam int MIN_WINDOW = 2;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // Largest and smallest distinct values with their runners-up.
    typedef struct packed {
        sample_t largest;
        sample_t second_largest;
        logic    second_largest_valid;
        sample_t smallest;
        sample_t second_smallest;
        logic    second_smallest_valid;
    } extremes_t;

endpackage

### hw/rtl/casd_extremes.sv
// ----------------------------------------------------------------------------
// casd_extremes: running extremes tracker
// Keeps the two largest and two smallest distinct samples of the current
// window and presents the record as it stands after the offered sample.
// ----------------------------------------------------------------------------
module casd_extremes
    import casd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  logic      first,
    input  sample_t   sample,
    output extremes_t ext_next
);

    extremes_t ext_reg;

    // Fold the offered sample into the record; the first sample restarts it.
    always_comb
    begin
        ext_next = ext_reg;
        if (first)
        begin
            ext_next.largest               = sample;
            ext_next.smallest              = sample;
            ext_next.second_largest        = '0;
            ext_next.second_smallest       = '0;
            ext_next.second_largest_valid  = 1'b0;
            ext_next.second_smallest_valid = 1'b0;
        end
        else
        begin
            if (sample > ext_reg.largest)
            begin
                ext_next.second_largest       = ext_reg.largest;
                ext_next.second_largest_valid = 1'b1;
                ext_next.largest              = sample;
            end
            else if (sample < ext_reg.largest &&
                     (!ext_reg.second_largest_valid || sample > ext_reg.second_largest))
            begin
                ext_next.second_largest       = sample;
                ext_next.second_largest_valid = 1'b1;
            end

            if (sample < ext_reg.smallest)
            begin
                ext_next.second_smallest       = ext_reg.smallest;
                ext_next.second_smallest_valid = 1'b1;
                ext_next.smallest              = sample;
            end
            else if (sample > ext_reg.smallest &&
                     (!ext_reg.second_smallest_valid || sample < ext_reg.second_smallest))
            begin
                ext_next.second_smallest       = sample;
                ext_next.second_smallest_valid = 1'b1;
            end
        end
    end

    // Record register, updated once per processed beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg <= '0;
        end
        else if (take)
        begin
            ext_reg <= ext_next;
        end
    end

endmodule

### hw/rtl/current_amplitude_switch_detector_unit.sv
// ----------------------------------------------------------------------------
// current_amplitude_switch_detector_unit: peak-to-peak load switch detector
// Gathers windows of current sensor samples, reports the spread of each
// window and decides whether the load is on.
//
//  Channel  | Direction | Handshake         | Payload
//  ---------+-----------+-------------------+--------------------------------
//  s_axis   | in        | tvalid / tready   | tdata: sample
//  m_axis   | out       | tvalid / tready   | tdata: amplitude, load_on, changed
//  cfg      | in        | cfg_valid / ready | cfg_index, cfg_data
//
// One sample beat is taken per cycle unless a window-ending sample is held by
// a result beat that is not taken. Each beat sits in the input register, where
// the extremes update, window count and amplitude compare are done, and the
// window's result then sits in the output register. Reset clears the window count,
// the switch state and both valid flags. A result beat that is not taken
// stalls only a window-ending sample; other samples keep flowing.
// ----------------------------------------------------------------------------
module current_amplitude_switch_detector_unit
    import casd_pkg::*;
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Sample stream. tdata: [9:0] sample, rest zero.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // Result stream. tdata: [9:0] amplitude, [10] load_on, [11] changed, rest zero.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // Configuration writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

    // Configuration registers.
    logic [WLEN_W-1:0] window_length_reg;
    logic [TRIM_W-1:0] trim_mode_reg;
    logic [THR_W-1:0]  on_threshold_reg;

    // Input register.
    logic              in_valid_reg;
    sample_t           in_sample_reg;

    // Window state.
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              switch_state_reg;

    // Output register.
    logic              out_valid_reg;
    sample_t           out_amplitude_reg;
    logic              out_load_on_reg;
    logic              out_changed_reg;

    logic              out_free;
    logic              advance;
    logic              first;
    logic              window_end;
    logic [LEN_W-1:0]  wlen_ext;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  count_inc;
    extremes_t         ext_next;
    sample_t           amplitude;
    logic              load_on;

    // Configuration port takes a write every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_LENGTH_RST;
            trim_mode_reg     <= TRIM_MODE_RST;
            on_threshold_reg  <= ON_THRESHOLD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH: window_length_reg <= cfg_data[WLEN_W-1:0];
                REG_TRIM_MODE:     trim_mode_reg     <= cfg_data[TRIM_W-1:0];
                REG_ON_THRESHOLD:  on_threshold_reg  <= cfg_data[THR_W-1:0];
                default:           ;
            endcase
        end
    end

    // Window length clamped to the supported range.
    assign wlen_ext = LEN_W'(window_length_reg);

    always_comb
    begin
        if (wlen_ext < LEN_W'(MIN_WINDOW))
        begin
            eff_len = LEN_W'(MIN_WINDOW);
        end
        else if (wlen_ext > LEN_W'(MAX_WINDOW))
        begin
            eff_len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = wlen_ext;
        end
    end

    // Window count and end detection for the beat in the input register.
    assign first      = (count_reg == '0);
    assign count_inc  = LEN_W'(count_reg) + LEN_W'(1);
    assign window_end = (count_inc >= eff_len);
    assign count_next = window_end ? '0 : count_inc[CNT_W-1:0];

    // Flow control: only a window-ending beat needs room at the output.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!window_end || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    // Running extremes of the window.
    casd_extremes u_extremes
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (advance),
        .first    (first),
        .sample   (in_sample_reg),
        .ext_next (ext_next)
    );

    // Amplitude of the window as it stands after this beat.
    always_comb
    begin
        amplitude = '0;
        if (trim_mode_reg[0])
        begin
            if (ext_next.second_largest_valid && ext_next.second_smallest_valid &&
                ext_next.second_largest >= ext_next.second_smallest)
            begin
                amplitude = ext_next.second_largest - ext_next.second_smallest;
            end
        end
        else if (ext_next.largest > ext_next.smallest)
        begin
            amplitude = ext_next.largest - ext_next.smallest;
        end
    end

    assign load_on = (THR_W'(amplitude) > on_threshold_reg);

    // Window count and switch state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            switch_state_reg <= 1'b0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            if (window_end)
            begin
                switch_state_reg <= load_on;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && window_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && window_end)
        begin
            out_amplitude_reg <= amplitude;
            out_load_on_reg   <= load_on;
            out_changed_reg   <= (load_on != switch_state_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_changed_reg, out_load_on_reg, out_amplitude_reg});

endmodule
